@@ hw/rtl/ptl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and constants for the priority trie prefix lookup block.
// ----------------------------------------------------------------------------
package ptl_pkg;

    // default configuration
    localparam int ADDRESS_BITS_DEF = 32;
    localparam int NODE_COUNT_DEF   = 4096;

    // fixed field widths of the transaction payloads
    localparam int ADDR_FIELD_W = 32;
    localparam int LEN_FIELD_W  = 6;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // status codes
    localparam logic STATUS_DONE      = 1'b0;
    localparam logic STATUS_POOL_FULL = 1'b1;

    // node kind stored in each trie entry
    typedef enum logic [1:0] {
        KIND_EMPTY    = 2'd0,
        KIND_ORDINARY = 2'd1,
        KIND_PRIORITY = 2'd2
    } t_kind;

    // engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FILL,
        ST_POST
    } t_state;

    // input transaction payload
    typedef struct packed {
        logic                    operation;
        logic [ADDR_FIELD_W-1:0] address;
        logic [LEN_FIELD_W-1:0]  prefix_length;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic                    match_found;
        logic [ADDR_FIELD_W-1:0] match_prefix;
        logic [LEN_FIELD_W-1:0]  match_length;
        logic                    status;
    } t_out_item;

endpackage

@@ hw/rtl/ptl_ram.sv @@
// ----------------------------------------------------------------------------
// ptl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/priority_trie_prefix_lookup.sv @@
// ----------------------------------------------------------------------------
// priority_trie_prefix_lookup
// Longest-prefix match engine on a binary priority trie held in a node RAM.
// ----------------------------------------------------------------------------
// One transaction at a time: an insert or a lookup is accepted, then walks
// the trie one level per cycle, each cycle reading the next node from the
// node RAM and, for an insert, writing back the current one. An insert that
// ends on an empty or newly allocated node then fills it in a fill step, and
// the result is registered from the post step into the output register.
// A new transaction can be taken in the cycle after the result is registered.
// A finished result waits in the output register while the next transaction
// is accepted; a second finished result waits in the engine until the output
// register frees up. No clearing pass is needed after reset.
module priority_trie_prefix_lookup
    import ptl_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int NODE_COUNT   = NODE_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int LEN_W  = $clog2(ADDRESS_BITS + 1);
    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int AB     = ADDRESS_BITS;

    // one trie entry in the node RAM
    typedef struct packed {
        logic [1:0][IDX_W-1:0] child;
        t_kind                 kind;
        logic [LEN_W-1:0]      length;
        logic [AB-1:0]         prefix;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // leading-ones mask of a prefix length
    function automatic logic [AB-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({AB{1'b1}} >> len);
    endfunction

    // branch bit at a trie level, counted from the msb
    function automatic logic branch_bit(input logic [AB-1:0] p,
                                        input logic [LEN_W-1:0] lvl);
        logic [AB-1:0] shifted;
        shifted    = p << lvl;
        branch_bit = shifted[AB-1];
    endfunction

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [AB-1:0]    r_p, n_p;
    logic [LEN_W-1:0] r_l, n_l;
    logic [LEN_W-1:0] r_level, n_level;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_nodes, n_nodes;
    logic             r_root, n_root;
    logic             r_found, n_found;
    logic [AB-1:0]    r_mp, n_mp;
    logic [LEN_W-1:0] r_ml, n_ml;
    logic             r_status, n_status;
    logic             r_o_valid, n_o_valid;
    t_out_item        r_o_data, n_o_data;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_node             ram_wnode;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [NODE_W-1:0] ram_rdata;

    ptl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wnode),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_nodes   <= '0;
            r_root    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_nodes   <= n_nodes;
            r_root    <= n_root;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_p      <= n_p;
        r_l      <= n_l;
        r_level  <= n_level;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_mp     <= n_mp;
        r_ml     <= n_ml;
        r_status <= n_status;
        r_o_data <= n_o_data;
    end

    // sequencer: walk, read-modify-write of the node RAM, result handoff
    always_comb begin
        t_node            nd;
        t_node            upd;
        logic [AB-1:0]    a_in;
        logic [LEN_W-1:0] l_in;
        logic [AB-1:0]    cp;
        logic [LEN_W-1:0] cl;
        logic             hit;
        logic             swap;
        logic             bsel;
        logic [IDX_W-1:0] c;
        logic             c_none;
        logic             at_bottom;
        logic             pool_full;
        logic [IDX_W-1:0] new_idx;

        n_state   = r_state;
        n_op      = r_op;
        n_p       = r_p;
        n_l       = r_l;
        n_level   = r_level;
        n_idx     = r_idx;
        n_nodes   = r_nodes;
        n_root    = r_root;
        n_found   = r_found;
        n_mp      = r_mp;
        n_ml      = r_ml;
        n_status  = r_status;
        n_o_data  = r_o_data;
        n_o_valid = r_o_valid && i_stall;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wnode = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        nd        = t_node'(ram_rdata);
        upd       = nd;
        a_in      = i_data.address[AB-1:0];
        l_in      = (i_data.prefix_length > LEN_FIELD_W'(AB)) ? LEN_W'(AB)
                                                              : i_data.prefix_length[LEN_W-1:0];
        cp        = r_p;
        cl        = r_l;
        hit       = (nd.kind != KIND_EMPTY) &&
                    (((r_p ^ nd.prefix) & len_mask(nd.length)) == '0);
        swap      = 1'b0;
        bsel      = 1'b0;
        c         = '0;
        c_none    = 1'b0;
        at_bottom = (r_level == LEN_W'(AB));
        pool_full = (r_nodes == IDX_W'(NODE_COUNT - 1));
        new_idx   = r_nodes + IDX_W'(1);

        case (r_state)
            // accept a transaction and start at the root
            ST_IDLE: begin
                if (i_valid) begin
                    n_op     = i_data.operation;
                    n_p      = (i_data.operation == OP_INSERT) ? (a_in & len_mask(l_in)) : a_in;
                    n_l      = l_in;
                    n_level  = '0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_mp     = '0;
                    n_ml     = '0;
                    n_status = STATUS_DONE;
                    if (!r_root) begin
                        n_state = (i_data.operation == OP_INSERT) ? ST_FILL : ST_POST;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = ST_WALK;
                    end
                end
            end

            // one trie level per cycle
            ST_WALK: begin
                if (r_op == OP_LOOKUP) begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_mp    = nd.prefix;
                        n_ml    = nd.length;
                    end
                    bsel   = branch_bit(r_p, r_level);
                    c      = nd.child[bsel];
                    c_none = (c == '0) || (32'(c) >= 32'(NODE_COUNT));
                    if ((hit && nd.kind == KIND_PRIORITY) || at_bottom || c_none) begin
                        n_state = ST_POST;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = c;
                        n_idx     = c;
                        n_level   = r_level + LEN_W'(1);
                    end
                end else if (nd.kind == KIND_EMPTY) begin
                    n_state = ST_FILL;
                end else if (nd.prefix == r_p && nd.length == r_l) begin
                    // duplicate entry, nothing changes
                    n_state = ST_POST;
                end else begin
                    // priority entry gives way to the carried prefix
                    swap = (nd.kind == KIND_PRIORITY) &&
                           ((r_l == r_level) ||
                            ((r_l > nd.length) &&
                             (((r_p ^ nd.prefix) & len_mask(nd.length)) == '0)));
                    if (swap) begin
                        upd.prefix = r_p;
                        upd.length = r_l;
                        if (r_l == r_level) begin
                            upd.kind = KIND_ORDINARY;
                        end
                        cp = nd.prefix;
                        cl = nd.length;
                    end
                    n_p       = cp;
                    n_l       = cl;
                    bsel      = branch_bit(cp, r_level);
                    c         = nd.child[bsel];
                    c_none    = (c == '0) || (32'(c) >= 32'(NODE_COUNT));
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wnode = upd;
                    if (at_bottom) begin
                        n_state = ST_POST;
                    end else if (c_none && pool_full) begin
                        n_status = STATUS_POOL_FULL;
                        n_state  = ST_POST;
                    end else if (c_none) begin
                        // hand out a pool node and fill it next cycle
                        upd.child[bsel] = new_idx;
                        ram_wnode       = upd;
                        n_nodes         = new_idx;
                        n_idx           = new_idx;
                        n_level         = r_level + LEN_W'(1);
                        n_state         = ST_FILL;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = c;
                        n_idx     = c;
                        n_level   = r_level + LEN_W'(1);
                    end
                end
            end

            // store the carried prefix in an empty node
            ST_FILL: begin
                ram_we           = 1'b1;
                ram_waddr        = r_idx;
                ram_wnode.child  = '0;
                ram_wnode.kind   = (r_l > r_level) ? KIND_PRIORITY : KIND_ORDINARY;
                ram_wnode.length = r_l;
                ram_wnode.prefix = r_p;
                n_root           = 1'b1;
                n_state          = ST_POST;
            end

            // hand the result to the output register
            ST_POST: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_data.match_found  = r_found;
                    n_o_data.match_prefix = ADDR_FIELD_W'(r_mp);
                    n_o_data.match_length = LEN_FIELD_W'(r_ml);
                    n_o_data.status       = r_status;
                    n_o_valid             = 1'b1;
                    n_state               = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

@@ hw/rtl/ptl_checker.sv @@
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks for the priority trie prefix lookup block.
// ----------------------------------------------------------------------------
module ptl_checker
    import ptl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // a stalled result stays offered and unchanged
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result transaction changed");

    // an accepted transaction is followed by a blocked input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a transaction is in progress");

    // a failed insert reports no match
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == STATUS_POOL_FULL) |->
        (!o_data.match_found && o_data.match_prefix == '0 && o_data.match_length == '0))
        else $error("pool full result carries match fields");

    // no match means zero prefix and length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.match_found) |->
        (o_data.match_prefix == '0 && o_data.match_length == '0))
        else $error("miss result carries a prefix");

endmodule

bind priority_trie_prefix_lookup ptl_checker u_ptl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority trie prefix lookup engine. A short
// table of inserts and lookups comes first, then a random mix built around
// the routes already stored. Results are checked against a trie model in
// the bench, or against the expected result where a table row gives one.
// ----------------------------------------------------------------------------
module testbench;
    import ptl_pkg::*;

    localparam int ADDR_W         = ADDRESS_BITS_DEF;
    localparam int NODES          = NODE_COUNT_DEF;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int IDLE_PCT       = 22;
    localparam int RX_HOLD_AT     = 600;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 60;
    localparam int ROUTE_KEEP     = 512;
    localparam int N_DIRECTED     = 23;

    // one row of the directed table
    typedef struct {
        logic                   op;
        logic [ADDR_W-1:0]      addr;
        logic [LEN_FIELD_W-1:0] len;
        bit                     typed;
        logic                   found;
        logic [ADDR_W-1:0]      mpfx;
        logic [LEN_FIELD_W-1:0] mlen;
        logic                   status;
    } t_row;

    // a route known to be stored, used to aim random traffic
    typedef struct {
        logic [ADDR_W-1:0] pfx;
        int unsigned       len;
    } t_route;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    // trie model state
    logic [ADDR_W-1:0]      node_pfx   [NODES];
    logic [LEN_FIELD_W-1:0] node_len   [NODES];
    t_kind                  node_kind  [NODES];
    int unsigned            node_child [NODES][2];
    int unsigned            nodes_used;
    bit                     root_used;

    t_out_item   pending_results [$];
    t_route      known_routes [$];
    t_out_item   head_result;
    int          mismatches   = 0;
    int          results_seen = 0;
    int          idle_cycles  = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_done = 1'b0;
    bit          tx_quiet     = 1'b0;
    logic        rx_quiet;

    // inserts and lookups, with the expected result only where it is obvious
    t_row directed_rows [N_DIRECTED] = '{
        '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h0A01_0203, 6'd0,  1'b1, 1'b1, 32'h0A00_0000, 6'd8, STATUS_DONE},
        '{OP_INSERT, 32'h0AFF_FFFF, 6'd16, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h0AFF_1234, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h0A7F_0000, 6'd5,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'hC0A8_0101, 6'd63, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'hC0A8_0101, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h0102_0304, 6'd33, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h0102_0304, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h1234_5678, 6'd0,  1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h8000_0000, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h0A12_3456, 6'd8,  1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h0000_0000, 6'd32, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'h8000_0000, 6'd1,  1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'hC000_0001, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_INSERT, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'hC0A8_0102, 6'd0,  1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE},
        '{OP_LOOKUP, 32'h7FFF_FFFF, 6'd32, 1'b0, 1'b0, 32'h0,         6'd0, STATUS_DONE}
    };

    priority_trie_prefix_lookup u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(int unsigned len);
        if (len == 0) return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    function automatic bit route_covers(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] pfx,
                                        int unsigned len);
        return ((addr ^ pfx) & prefix_mask(len)) == '0;
    endfunction

    function automatic void clear_node(int unsigned idx);
        node_pfx[idx]      = '0;
        node_len[idx]      = '0;
        node_kind[idx]     = KIND_EMPTY;
        node_child[idx][0] = 0;
        node_child[idx][1] = 0;
    endfunction

    // an entry longer than its level is a priority entry
    function automatic void place_entry(int unsigned idx, logic [ADDR_W-1:0] pfx,
                                        logic [LEN_FIELD_W-1:0] len, int unsigned lvl);
        node_pfx[idx]  = pfx;
        node_len[idx]  = len;
        node_kind[idx] = (len > lvl) ? KIND_PRIORITY : KIND_ORDINARY;
    endfunction

    // applies one transaction to the trie model and returns its result
    function automatic t_out_item trie_outcome(t_in_item it);
        t_out_item              res;
        int unsigned            idx;
        int unsigned            child;
        logic                   dir;
        logic [ADDR_W-1:0]      pfx;
        logic [LEN_FIELD_W-1:0] len;
        logic [ADDR_W-1:0]      held_pfx;
        logic [LEN_FIELD_W-1:0] held_len;
        res = '0;
        idx = 0;
        if (it.operation == OP_LOOKUP) begin
            if (!root_used) return res;
            // keep the last covering entry, stop at a covering priority entry
            for (int unsigned lvl = 0; lvl <= ADDR_W; lvl++) begin
                if (node_kind[idx] != KIND_EMPTY &&
                        route_covers(it.address, node_pfx[idx], node_len[idx])) begin
                    res.match_found  = 1'b1;
                    res.match_prefix = node_pfx[idx];
                    res.match_length = node_len[idx];
                    if (node_kind[idx] == KIND_PRIORITY) return res;
                end
                if (lvl >= ADDR_W) return res;
                child = node_child[idx][it.address[ADDR_W-1-lvl]];
                if (child == 0) return res;
                idx = child;
            end
            return res;
        end
        // insert: clip the length and clear the host bits
        len = (it.prefix_length > LEN_FIELD_W'(ADDR_W)) ? LEN_FIELD_W'(ADDR_W)
                                                        : it.prefix_length;
        pfx = it.address & prefix_mask(len);
        res.status = STATUS_DONE;
        if (!root_used) begin
            clear_node(0);
            place_entry(0, pfx, len, 0);
            root_used = 1'b1;
            return res;
        end
        for (int unsigned lvl = 0; lvl <= ADDR_W; lvl++) begin
            if (node_kind[idx] == KIND_EMPTY) begin
                place_entry(idx, pfx, len, lvl);
                return res;
            end
            // route already stored: nothing changes
            if (node_pfx[idx] == pfx && node_len[idx] == len) return res;
            // priority slot goes to a route of the level's length or to a longer
            // route under the stored one; the old route travels on down
            if (node_kind[idx] == KIND_PRIORITY && (len == lvl ||
                    (len > node_len[idx] && route_covers(pfx, node_pfx[idx], node_len[idx]))))
            begin
                held_pfx      = node_pfx[idx];
                held_len      = node_len[idx];
                node_pfx[idx] = pfx;
                node_len[idx] = len;
                if (len == lvl) node_kind[idx] = KIND_ORDINARY;
                pfx = held_pfx;
                len = held_len;
            end
            if (lvl >= ADDR_W) return res;
            dir   = pfx[ADDR_W-1-lvl];
            child = node_child[idx][dir];
            if (child == 0) begin
                // pool exhausted: the carried route is dropped
                if (nodes_used + 1 >= NODES) begin
                    res.status = STATUS_POOL_FULL;
                    return res;
                end
                nodes_used++;
                child = nodes_used;
                clear_node(child);
                node_child[idx][dir] = child;
            end
            idx = child;
        end
        return res;
    endfunction

    // random transaction, mostly aimed at or around stored routes
    function automatic t_in_item random_item();
        t_in_item    it;
        t_route      r;
        int unsigned pick;
        it.operation     = ($urandom_range(99) < 45) ? OP_LOOKUP : OP_INSERT;
        it.address       = $urandom();
        it.prefix_length = LEN_FIELD_W'($urandom_range(63));
        if (known_routes.size() == 0) return it;
        r    = known_routes[$urandom_range(known_routes.size() - 1)];
        pick = $urandom_range(99);
        if (it.operation == OP_LOOKUP) begin
            if (pick < 75) it.address = r.pfx | (it.address & ~prefix_mask(r.len));
        end else if (pick < 35) begin
            // longer route nested under a stored one
            it.address       = r.pfx | (it.address & ~prefix_mask(r.len));
            it.prefix_length = LEN_FIELD_W'($urandom_range(ADDR_W, r.len));
        end else if (pick < 50) begin
            // shorter route covering a stored one
            it.address       = r.pfx;
            it.prefix_length = LEN_FIELD_W'($urandom_range(r.len, 0));
        end else if (pick < 60) begin
            // same route again with scrambled host bits
            it.address       = r.pfx | (it.address & ~prefix_mask(r.len));
            it.prefix_length = LEN_FIELD_W'(r.len);
        end else if (pick < 90) begin
            it.prefix_length = LEN_FIELD_W'($urandom_range(ADDR_W, 8));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %h want %h (result %0d)",
                     $time, what, got, want, results_seen);
    endtask

    // predicts, offers the transaction and waits for it to be taken
    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item   predicted;
        int unsigned len;
        predicted = trie_outcome(it);
        if (it.operation == OP_INSERT && predicted.status == STATUS_DONE &&
                known_routes.size() < ROUTE_KEEP) begin
            len = (it.prefix_length > ADDR_W) ? ADDR_W : it.prefix_length;
            known_routes.push_back('{it.address & prefix_mask(len), len});
        end
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // receiver: random stalls, one long hold-off, one quiet stretch
    assign rx_quiet = (results_seen >= 1000 && results_seen < 1300);

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            i_stall      <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else if (!rx_hold_done && results_seen == RX_HOLD_AT) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= RX_HOLD_CYCLES;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result check against the oldest pending expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_data.match_prefix, '0);
            end else begin
                head_result = pending_results.pop_front();
                if (o_data.match_found !== head_result.match_found)
                    report_mismatch("match_found", o_data.match_found,
                                    head_result.match_found);
                if (o_data.match_prefix !== head_result.match_prefix)
                    report_mismatch("match_prefix", o_data.match_prefix,
                                    head_result.match_prefix);
                if (o_data.match_length !== head_result.match_length)
                    report_mismatch("match_length", o_data.match_length,
                                    head_result.match_length);
                if (o_data.status !== head_result.status)
                    report_mismatch("status", o_data.status, head_result.status);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        t_in_item  it;
        t_out_item typed_res;
        for (int unsigned k = 0; k < NODES; k++) clear_node(k);
        nodes_used = 0;
        root_used  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[k]) begin
            it.operation           = directed_rows[k].op;
            it.address             = directed_rows[k].addr;
            it.prefix_length       = directed_rows[k].len;
            typed_res.match_found  = directed_rows[k].found;
            typed_res.match_prefix = directed_rows[k].mpfx;
            typed_res.match_length = directed_rows[k].mlen;
            typed_res.status       = directed_rows[k].status;
            send_item(it, directed_rows[k].typed, typed_res);
        end
        wait_all_results();

        // random mix, with one stretch of back-to-back offers
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            tx_quiet = (n >= 900 && n < 1200);
            if (n == 1200) wait_all_results();
            send_item(random_item(), 1'b0, '0);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
